// File: design/mlnr_pkg.sv
// ----------------------------------------------------------------------------
// mlnr_pkg
// Shared types and codes for the loop note recorder.
// ----------------------------------------------------------------------------
package mlnr_pkg;

    localparam logic [1:0] CMD_EVENT  = 2'd0;
    localparam logic [1:0] CMD_START  = 2'd1;
    localparam logic [1:0] CMD_FLUSH  = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [1:0] KIND_NOTE = 2'd0;
    localparam logic [1:0] KIND_CTRL = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    localparam logic CFG_LOOP_LENGTH = 1'b0;
    localparam logic CFG_SAMPLES_PER_BEAT = 1'b1;

    localparam int TABLE_DEPTH = 2048;
    localparam int IDX_W = 11;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_SCAN,
        ST_SCAN_READ,
        ST_MOD_BASE,
        ST_DIV_OFF,
        ST_MOD_EV,
        ST_LOOKUP,
        ST_DECIDE,
        ST_OUT
    } state_t;

    // request to the shared divider
    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quotient;
        logic [31:0] remainder;
    } div_rsp_t;

endpackage

// File: design/mlnr_divider.sv
// ----------------------------------------------------------------------------
// mlnr_divider
// Restoring divider, one quotient bit per cycle, 64 by 32 bits.
// ----------------------------------------------------------------------------
module mlnr_divider (
    input  logic               clk,
    input  logic               rst_n,
    input  mlnr_pkg::div_req_t req,
    output mlnr_pkg::div_rsp_t rsp
);
    import mlnr_pkg::*;

    logic [63:0] quot_reg;
    logic [32:0] rem_reg;
    logic [31:0] dsr_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [32:0] trial;
    logic [32:0] shifted;

    // one restoring step
    always_comb
    begin
        shifted = {rem_reg[31:0], quot_reg[63]};
        trial   = shifted - {1'b0, dsr_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 7'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quot_reg <= req.dividend;
            rem_reg  <= 33'd0;
            dsr_reg  <= req.divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[32])
            begin
                rem_reg  <= trial;
                quot_reg <= {quot_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg  <= shifted;
                quot_reg <= {quot_reg[62:0], 1'b0};
            end
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quot_reg;
    assign rsp.remainder = rem_reg[31:0];

    property p_done_pulse;
        @(posedge clk) disable iff (!rst_n) done_reg |=> !done_reg;
    endproperty
    a_done_pulse: assert property (p_done_pulse) else $error("divider done held");

    property p_start_busy;
        @(posedge clk) disable iff (!rst_n) req.start |=> busy_reg;
    endproperty
    a_start_busy: assert property (p_start_busy) else $error("divider not busy");

    property p_done_idle;
        @(posedge clk) disable iff (!rst_n) done_reg |-> !busy_reg;
    endproperty
    a_done_idle: assert property (p_done_idle) else $error("divider busy at done");

endmodule

// File: design/midi_loop_note_recorder.sv
// ----------------------------------------------------------------------------
// midi_loop_note_recorder
// Records MIDI events into loop-local note and control records.
// ----------------------------------------------------------------------------
// Each request is handled alone, and the input stalls while one is in work or
// a result waits. A MIDI event that passes the status and recording checks
// runs three passes of one shared 64-bit restoring divider (block beat modulo
// loop length, sample offset over samples per beat, sum modulo loop length),
// then a table read and a decision. An event dropped for its status, a zero
// register or recording off returns to idle from the first divider state, and
// an unused command never leaves idle. A start command clears the held-note
// table, one entry a cycle. A flush step scans the table from entry zero, one
// entry a cycle, until it finds a held note. Out of reset the block first
// clears the whole table with its input stalled.
module midi_loop_note_recorder #(
    parameter int BEAT_FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [31:0] block_start_beat,
    input  logic [11:0] sample_offset,
    input  logic [7:0]  status_byte,
    input  logic [6:0]  data_one,
    input  logic [6:0]  data_two,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [31:0] start_beat,
    output logic [31:0] note_length,
    output logic [4:0]  channel,
    output logic [7:0]  status_out,
    output logic [6:0]  first_byte,
    output logic [6:0]  second_byte
);
    import mlnr_pkg::*;

    localparam int ONE_RAW = 1 << BEAT_FRAC_BITS;
    localparam int EPS_RAW = (ONE_RAW + 500) / 1000;
    localparam logic [32:0] EPS = (EPS_RAW == 0) ? 33'd1 : 33'(EPS_RAW);

    // table entry: held flag, start, velocity
    logic [39:0] mem [TABLE_DEPTH];
    logic [39:0] rd_reg;
    logic [IDX_W-1:0] rd_addr;
    logic        wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [39:0] wr_data;

    state_t state_reg, state_next;

    logic [31:0] loop_reg, spb_reg;
    logic        rec_reg;
    logic [31:0] bsb_reg;
    logic [11:0] so_reg;
    logic [7:0]  st_reg;
    logic [6:0]  d1_reg, d2_reg;
    logic [31:0] base_reg, ev_reg;
    logic [63:0] sum_reg;
    logic [IDX_W:0] cnt_reg;
    logic        div_wait_reg;

    logic        ov_reg;
    logic [1:0]  kind_reg;
    logic [31:0] sb_reg, len_reg;
    logic [4:0]  ch_reg;
    logic [7:0]  so_out_reg;
    logic [6:0]  b1_reg, b2_reg;

    div_req_t dreq;
    div_rsp_t drsp;

    logic        accept;
    logic [IDX_W-1:0] ev_idx;
    logic [IDX_W-1:0] scan_idx;
    logic        is_chan;
    logic        ev_skip;
    logic [3:0]  ev_type;

    assign accept  = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE) || ov_reg;
    assign ev_type = st_reg[7:4];
    assign ev_idx  = {st_reg[3:0], d1_reg};
    assign is_chan = st_reg[7] && (st_reg[7:4] != 4'hF);
    assign ev_skip = !rec_reg || loop_reg == 32'd0 || spb_reg == 32'd0 || !is_chan;
    // entry held in rd_reg during the scan
    assign scan_idx = cnt_reg[IDX_W-1:0] - IDX_W'(1);

    mlnr_divider u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (dreq),
        .rsp  (drsp)
    );

    // table memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_reg <= mem[rd_addr];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
            begin
                if (cnt_reg[IDX_W-1:0] == IDX_W'(TABLE_DEPTH - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd == CMD_START)
                        state_next = ST_CLEAR;
                    else if (cmd == CMD_FLUSH)
                        state_next = ST_SCAN;
                    else if (cmd == CMD_EVENT)
                        state_next = ST_MOD_BASE;
                end
            end
            ST_CLEAR:
            begin
                if (cnt_reg[IDX_W-1:0] == IDX_W'(TABLE_DEPTH - 1))
                    state_next = ST_IDLE;
            end
            ST_SCAN:
                state_next = ST_SCAN_READ;
            ST_SCAN_READ:
            begin
                if (rd_reg[39] || cnt_reg[IDX_W])
                    state_next = ST_OUT;
                else
                    state_next = ST_SCAN_READ;
            end
            ST_MOD_BASE:
            begin
                if (ev_skip)
                    state_next = ST_IDLE;
                else if (div_wait_reg && drsp.done)
                    state_next = ST_DIV_OFF;
            end
            ST_DIV_OFF:
            begin
                if (div_wait_reg && drsp.done)
                    state_next = ST_MOD_EV;
            end
            ST_MOD_EV:
            begin
                if (div_wait_reg && drsp.done)
                    state_next = ST_LOOKUP;
            end
            ST_LOOKUP:
                state_next = ST_DECIDE;
            ST_DECIDE:
            begin
                if ((ev_type == 4'h9 && d2_reg != 7'd0) ||
                    ((ev_type == 4'h8 || ev_type == 4'h9) && !rd_reg[39]) ||
                    !(ev_type == 4'h8 || ev_type == 4'h9 ||
                      ev_type == 4'hB || ev_type == 4'hE))
                    state_next = ST_IDLE;
                else
                    state_next = ST_OUT;
            end
            ST_OUT:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer: memory and divider control
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = cnt_reg[IDX_W-1:0];
        wr_data = 40'd0;
        rd_addr = cnt_reg[IDX_W-1:0];
        dreq.start    = 1'b0;
        dreq.dividend = 64'd0;
        dreq.divisor  = loop_reg;
        case (state_reg)
            ST_INIT:
                wr_en = 1'b1;
            ST_CLEAR:
                wr_en = 1'b1;
            ST_MOD_BASE:
            begin
                dreq.start    = !div_wait_reg && !ev_skip;
                dreq.dividend = {32'd0, bsb_reg};
            end
            ST_DIV_OFF:
            begin
                dreq.start    = !div_wait_reg;
                dreq.dividend = {52'd0, so_reg} << (2 * BEAT_FRAC_BITS);
                dreq.divisor  = spb_reg;
            end
            ST_MOD_EV:
            begin
                dreq.start    = !div_wait_reg;
                dreq.dividend = sum_reg;
            end
            ST_LOOKUP:
                rd_addr = ev_idx;
            ST_DECIDE:
            begin
                rd_addr = ev_idx;
                wr_addr = ev_idx;
                if (ev_type == 4'h9 && d2_reg != 7'd0)
                begin
                    wr_en   = 1'b1;
                    wr_data = {1'b1, ev_reg, d2_reg};
                end
                else if ((ev_type == 4'h8 || ev_type == 4'h9) && rd_reg[39])
                begin
                    wr_en = 1'b1;
                end
            end
            ST_SCAN_READ:
            begin
                // cnt_reg points one past the entry in rd_reg
                rd_addr = cnt_reg[IDX_W-1:0];
                wr_addr = scan_idx;
                wr_en   = rd_reg[39];
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    // note-off length
    logic signed [33:0] d0, d1, d2;
    always_comb
    begin
        d0 = $signed({2'b00, ev_reg}) - $signed({2'b00, rd_reg[38:7]});
        d1 = (d0 <= 0) ? d0 + $signed({2'b00, loop_reg}) : d0;
        d2 = (d1 >= $signed({2'b00, loop_reg})) ?
             $signed({2'b00, loop_reg}) - $signed({1'b0, EPS}) : d1;
        if (d2 < 0)
            d2 = 34'sd0;
    end

    // sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_INIT;
            loop_reg     <= 32'd262144;
            spb_reg      <= 32'd1572864000;
            rec_reg      <= 1'b0;
            ov_reg       <= 1'b0;
            cnt_reg      <= '0;
            div_wait_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                if (cfg_index == CFG_LOOP_LENGTH)
                    loop_reg <= cfg_data;
                else
                    spb_reg <= cfg_data;
            end
            if (out_valid && !out_stall)
                ov_reg <= 1'b0;
            if (dreq.start)
                div_wait_reg <= 1'b1;
            else if (drsp.done)
                div_wait_reg <= 1'b0;
            case (state_reg)
                ST_INIT:
                    cnt_reg <= cnt_reg + 1'b1;
                ST_IDLE:
                    cnt_reg <= '0;
                ST_CLEAR:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    rec_reg <= 1'b1;
                end
                ST_SCAN:
                    cnt_reg <= cnt_reg + 1'b1;
                ST_SCAN_READ:
                begin
                    if (!rd_reg[39] && !cnt_reg[IDX_W])
                        cnt_reg <= cnt_reg + 1'b1;
                    if (!rd_reg[39] && cnt_reg[IDX_W])
                        rec_reg <= 1'b0;
                end
                ST_OUT:
                    ov_reg <= 1'b1;
                ST_DECIDE:
                begin
                    if (state_next == ST_OUT)
                        ov_reg <= 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            bsb_reg <= block_start_beat;
            so_reg  <= sample_offset;
            st_reg  <= status_byte;
            d1_reg  <= data_one;
            d2_reg  <= data_two;
        end
        if (drsp.done && state_reg == ST_MOD_BASE)
            base_reg <= drsp.remainder;
        if (drsp.done && state_reg == ST_DIV_OFF)
            sum_reg <= {32'd0, base_reg} + drsp.quotient;
        if (drsp.done && state_reg == ST_MOD_EV)
            ev_reg <= drsp.remainder;
        if (state_reg == ST_SCAN_READ)
        begin
            if (rd_reg[39])
            begin
                kind_reg   <= KIND_NOTE;
                sb_reg     <= rd_reg[38:7];
                len_reg    <= (rd_reg[38:7] < loop_reg) ? loop_reg - rd_reg[38:7]
                                                        : loop_reg;
                ch_reg     <= {1'b0, scan_idx[IDX_W-1:7]} + 5'd1;
                so_out_reg <= 8'd0;
                b1_reg     <= scan_idx[6:0];
                b2_reg     <= rd_reg[6:0];
            end
            else
            begin
                kind_reg   <= KIND_DONE;
                sb_reg     <= 32'd0;
                len_reg    <= 32'd0;
                ch_reg     <= 5'd0;
                so_out_reg <= 8'd0;
                b1_reg     <= 7'd0;
                b2_reg     <= 7'd0;
            end
        end
        if (state_reg == ST_DECIDE)
        begin
            ch_reg <= {1'b0, st_reg[3:0]} + 5'd1;
            b1_reg <= d1_reg;
            if (ev_type == 4'hB || ev_type == 4'hE)
            begin
                kind_reg   <= KIND_CTRL;
                sb_reg     <= ev_reg;
                len_reg    <= 32'd0;
                so_out_reg <= st_reg;
                b2_reg     <= d2_reg;
            end
            else
            begin
                kind_reg   <= KIND_NOTE;
                sb_reg     <= rd_reg[38:7];
                len_reg    <= d2[31:0];
                so_out_reg <= 8'd0;
                b2_reg     <= rd_reg[6:0];
            end
        end
    end

    assign out_valid   = ov_reg;
    assign kind        = kind_reg;
    assign start_beat  = sb_reg;
    assign note_length = len_reg;
    assign channel     = ch_reg;
    assign status_out  = so_out_reg;
    assign first_byte  = b1_reg;
    assign second_byte = b2_reg;

    property p_stall_busy;
        @(posedge clk) disable iff (!rst_n) (state_reg != ST_IDLE) |-> in_stall;
    endproperty
    a_stall_busy: assert property (p_stall_busy) else $error("request taken while busy");

    property p_out_after_seq;
        @(posedge clk) disable iff (!rst_n) $rose(ov_reg) |-> $past(state_reg == ST_OUT);
    endproperty
    a_out_after_seq: assert property (p_out_after_seq) else $error("result without sequence");

    property p_div_in_event;
        @(posedge clk) disable iff (!rst_n)
            dreq.start |-> (state_reg == ST_MOD_BASE || state_reg == ST_DIV_OFF ||
                            state_reg == ST_MOD_EV);
    endproperty
    a_div_in_event: assert property (p_div_in_event) else $error("stray divider start");

endmodule

// File: tb/sv/midi_loop_note_recorder_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// midi_loop_note_recorder_checker
// Watches the request, result and register ports of the loop note recorder,
// predicts every record from its own copy of the held-note table and the
// loop registers, and compares each accepted result with the oldest one due.
// ----------------------------------------------------------------------------
module midi_loop_note_recorder_checker #(
    parameter int BEAT_FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [31:0] block_start_beat,
    input  logic [11:0] sample_offset,
    input  logic [7:0]  status_byte,
    input  logic [6:0]  data_one,
    input  logic [6:0]  data_two,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [1:0]  kind,
    input  logic [31:0] start_beat,
    input  logic [31:0] note_length,
    input  logic [4:0]  channel,
    input  logic [7:0]  status_out,
    input  logic [6:0]  first_byte,
    input  logic [6:0]  second_byte,
    output int          fail_count,
    output int          pending
);
    import mlnr_pkg::*;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] start_beat;
        logic [31:0] note_length;
        logic [4:0]  channel;
        logic [7:0]  status_out;
        logic [6:0]  first_byte;
        logic [6:0]  second_byte;
    } record_t;

    localparam int CLOSE_MARGIN = ((1 << BEAT_FRAC_BITS) + 500) / 1000 == 0 ? 1 :
                                  ((1 << BEAT_FRAC_BITS) + 500) / 1000;

    record_t     due_records[$];
    logic [31:0] loop_len;
    logic [31:0] spb;
    logic        rec_on;
    bit          held[TABLE_DEPTH];
    logic [31:0] held_beat[TABLE_DEPTH];
    logic [6:0]  held_vel[TABLE_DEPTH];

    // work out the record, if any, that one accepted request causes
    task automatic record_request();
        record_t     r;
        logic [3:0]  typ;
        logic [10:0] idx;
        logic [63:0] base;
        logic [63:0] off;
        logic [63:0] ev;
        longint      d;
        bit          found;
        r = '0;
        typ = status_byte[7:4];
        idx = {status_byte[3:0], data_one};
        found = 0;
        if (cmd == CMD_START) begin
            for (int i = 0; i < TABLE_DEPTH; i++) held[i] = 0;
            rec_on = 1'b1;
        end else if (cmd == CMD_FLUSH) begin
            for (int i = 0; i < TABLE_DEPTH && !found; i++) begin
                if (held[i]) begin
                    found = 1;
                    held[i] = 0;
                    r.kind = KIND_NOTE;
                    r.start_beat = held_beat[i];
                    r.note_length = (held_beat[i] < loop_len) ? loop_len - held_beat[i]
                                                              : loop_len;
                    r.channel = 5'(i >> 7) + 5'd1;
                    r.first_byte = 7'(i);
                    r.second_byte = held_vel[i];
                end
            end
            if (!found) begin
                rec_on = 1'b0;
                r.kind = KIND_DONE;
            end
            due_records.push_back(r);
        end else if (cmd == CMD_EVENT && rec_on && loop_len != 0 && spb != 0
                     && status_byte >= 8'h80 && status_byte < 8'hF0) begin
            base = 64'(block_start_beat) % 64'(loop_len);
            off = (64'(sample_offset) << (2 * BEAT_FRAC_BITS)) / 64'(spb);
            ev = (base + off) % 64'(loop_len);
            if (typ == 4'h9 && data_two != 0) begin
                held[idx] = 1;
                held_beat[idx] = ev[31:0];
                held_vel[idx] = data_two;
            end else if ((typ == 4'h8 || typ == 4'h9) && held[idx]) begin
                d = longint'(ev) - longint'(held_beat[idx]);
                if (d <= 0) d += longint'(loop_len);
                if (d >= longint'(loop_len)) d = longint'(loop_len) - CLOSE_MARGIN;
                if (d < 0) d = 0;
                r.kind = KIND_NOTE;
                r.start_beat = held_beat[idx];
                r.note_length = d[31:0];
                r.channel = {1'b0, status_byte[3:0]} + 5'd1;
                r.first_byte = data_one;
                r.second_byte = held_vel[idx];
                held[idx] = 0;
                due_records.push_back(r);
            end else if (typ == 4'hB || typ == 4'hE) begin
                r.kind = KIND_CTRL;
                r.start_beat = ev[31:0];
                r.channel = {1'b0, status_byte[3:0]} + 5'd1;
                r.status_out = status_byte;
                r.first_byte = data_one;
                r.second_byte = data_two;
                due_records.push_back(r);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        record_t got;
        record_t want;
        if (!rst_n) begin
            due_records.delete();
            loop_len <= 32'd262144;
            spb <= 32'd1572864000;
            rec_on = 1'b0;
            for (int i = 0; i < TABLE_DEPTH; i++) held[i] = 0;
            fail_count <= 0;
            pending <= 0;
        end else begin
            // register writes
            if (cfg_write) begin
                if (cfg_index == CFG_LOOP_LENGTH) loop_len <= cfg_data;
                else spb <= cfg_data;
            end
            // accepted results against the oldest record due
            if (out_valid && !out_stall) begin
                got = '{kind, start_beat, note_length, channel, status_out,
                        first_byte, second_byte};
                if (due_records.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    fail_count <= fail_count + 1;
                end else begin
                    want = due_records.pop_front();
                    if (got.kind != want.kind || got.start_beat != want.start_beat ||
                        got.note_length != want.note_length ||
                        got.channel != want.channel ||
                        got.status_out != want.status_out ||
                        got.first_byte != want.first_byte ||
                        got.second_byte != want.second_byte) begin
                        $display("%0t: mismatch expected k%0d s%h l%h c%0d st%h b%h v%h",
                                 $time, want.kind, want.start_beat, want.note_length,
                                 want.channel, want.status_out, want.first_byte,
                                 want.second_byte);
                        $display("%0t:          actual   k%0d s%h l%h c%0d st%h b%h v%h",
                                 $time, got.kind, got.start_beat, got.note_length,
                                 got.channel, got.status_out, got.first_byte,
                                 got.second_byte);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            // accepted requests
            if (in_valid && !in_stall) record_request();
            pending <= due_records.size();
        end
    end

endmodule

// File: tb/sv/midi_loop_note_recorder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// midi_loop_note_recorder_tb
// Drives directed and random MIDI, start and flush requests through several
// loop settings with random idling on both sides; the checker predicts and
// compares every record and this top gives the verdict.
// ----------------------------------------------------------------------------
module midi_loop_note_recorder_tb;
    import mlnr_pkg::*;

    localparam int SETTLE_CYCLES = 2500;

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic        cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  cmd;
    logic [31:0] block_start_beat;
    logic [11:0] sample_offset;
    logic [7:0]  status_byte;
    logic [6:0]  data_one;
    logic [6:0]  data_two;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  kind;
    logic [31:0] start_beat;
    logic [31:0] note_length;
    logic [4:0]  channel;
    logic [7:0]  status_out;
    logic [6:0]  first_byte;
    logic [6:0]  second_byte;
    int          fail_count;
    int          pending;
    int          cycle_no = 0;
    int          req_no;

    midi_loop_note_recorder u_dut (.*);
    midi_loop_note_recorder_checker u_chk (.*);

    // clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // result side: random stalls, one long hold-off, one quiet stretch
    always @(posedge clk)
    begin
        cycle_no <= cycle_no + 1;
        if (cycle_no >= 40000 && cycle_no < 46000) out_stall <= 1'b1;
        else if (cycle_no >= 80000 && cycle_no < 120000) out_stall <= 1'b0;
        else out_stall <= ($urandom_range(99) < 15);
    end

    // send one request and wait until it is taken
    task automatic send_req(input logic [1:0] c, input logic [31:0] bsb,
                            input logic [11:0] so, input logic [7:0] st,
                            input logic [6:0] d1, input logic [6:0] d2);
        int gap;
        in_valid <= 1'b1;
        cmd <= c;
        block_start_beat <= bsb;
        sample_offset <= so;
        status_byte <= st;
        data_one <= d1;
        data_two <= d2;
        forever
        begin
            @(negedge clk);
            if (!in_stall) break;
        end
        @(posedge clk);
        req_no++;
        if ((req_no < 300 || req_no > 420) && $urandom_range(99) < 15) begin
            gap = $urandom_range(1, 12);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // wait until every record has come and the block has gone quiet
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        forever
        begin
            @(negedge clk);
            if (pending == 0) break;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_loop(input logic [31:0] len, input logic [31:0] rate);
        drain();
        cfg_write <= 1'b1;
        cfg_index <= CFG_LOOP_LENGTH;
        cfg_data <= len;
        @(posedge clk);
        cfg_index <= CFG_SAMPLES_PER_BEAT;
        cfg_data <= rate;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // random traffic: well-formed note pairs on a small pool, some noise
    task automatic random_phase(input int count);
        logic [7:0] st;
        logic [6:0] p;
        int         pick;
        send_req(CMD_START, '0, '0, '0, '0, '0);
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            st = {4'h9, 4'($urandom_range(3))};
            p = 7'($urandom_range(60, 63));
            if (pick < 3) begin
                send_req(CMD_START, $urandom, 12'($urandom), 8'($urandom),
                         7'($urandom), 7'($urandom));
            end else if (pick < 8) begin
                repeat ($urandom_range(1, 5))
                    send_req(CMD_FLUSH, $urandom, 12'($urandom), 8'($urandom),
                             7'($urandom), 7'($urandom));
                if ($urandom_range(1)) send_req(CMD_START, '0, '0, '0, '0, '0);
            end else if (pick < 10) begin
                send_req(CMD_UNUSED, $urandom, 12'($urandom), 8'($urandom),
                         7'($urandom), 7'($urandom));
            end else begin
                if (pick < 45) st[7:4] = 4'h9;
                else if (pick < 70) st[7:4] = 4'h8;
                else if (pick < 80) st[7:4] = 4'hB;
                else if (pick < 85) st[7:4] = 4'hE;
                else st = 8'($urandom);
                if (pick >= 85 || $urandom_range(3) == 0) p = 7'($urandom);
                if ($urandom_range(1)) st[3:0] = 4'($urandom);
                send_req(CMD_EVENT, $urandom, 12'($urandom), st, p,
                         ($urandom_range(9) == 0) ? 7'd0 : 7'($urandom));
            end
        end
        repeat (8) send_req(CMD_FLUSH, '0, '0, '0, '0, '0);
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_no = 0;
        in_valid = 1'b0;
        cfg_write = 1'b0;
        cfg_index = CFG_LOOP_LENGTH;
        cfg_data = '0;
        cmd = CMD_EVENT;
        block_start_beat = '0;
        sample_offset = '0;
        status_byte = '0;
        data_one = '0;
        data_two = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset settings
        send_req(CMD_START, '0, '0, '0, '0, '0);
        send_req(CMD_EVENT, '0, '0, 8'h90, '0, 7'd127);
        send_req(CMD_EVENT, 32'hFFFF_FFFF, 12'hFFF, 8'h80, '0, '0);
        send_req(CMD_EVENT, 32'h0001_0000, '0, 8'h9F, 7'd127, 7'd1);
        send_req(CMD_EVENT, 32'h0001_8000, 12'd100, 8'h9F, 7'd127, 7'd0);
        send_req(CMD_EVENT, '0, '0, 8'h85, 7'd5, 7'd5);
        send_req(CMD_EVENT, '0, '0, 8'h7F, 7'd1, 7'd1);
        send_req(CMD_EVENT, '0, '0, 8'hF0, 7'd1, 7'd1);
        send_req(CMD_EVENT, '0, '0, 8'hFF, 7'd1, 7'd1);
        send_req(CMD_EVENT, '0, '0, 8'hA3, 7'd1, 7'd1);
        send_req(CMD_EVENT, '0, '0, 8'hC3, 7'd1, 7'd1);
        send_req(CMD_EVENT, 32'h0002_0000, 12'hFFF, 8'hB7, 7'd127, 7'd127);
        send_req(CMD_EVENT, 32'h0003_0000, 12'd1, 8'hEF, 7'd0, 7'd64);
        send_req(CMD_EVENT, 32'h0002_0000, '0, 8'h92, 7'd40, 7'd100);
        send_req(CMD_EVENT, 32'h0002_0000, '0, 8'h82, 7'd40, 7'd0);
        send_req(CMD_EVENT, 32'h0003_0000, '0, 8'h91, 7'd10, 7'd20);
        send_req(CMD_UNUSED, '0, '0, 8'h90, '0, '0);
        send_req(CMD_FLUSH, '0, '0, '0, '0, '0);
        send_req(CMD_FLUSH, '0, '0, '0, '0, '0);
        send_req(CMD_EVENT, '0, '0, 8'hB0, 7'd1, 7'd1);
        send_req(CMD_START, '0, '0, '0, '0, '0);
        send_req(CMD_EVENT, '0, '0, 8'h90, 7'd1, 7'd1);
        send_req(CMD_START, '0, '0, '0, '0, '0);
        send_req(CMD_FLUSH, '0, '0, '0, '0, '0);

        // random phases over several loop settings
        random_phase(90);
        set_loop(32'hFFFF_FFFF, 32'd1);
        random_phase(70);
        set_loop(32'd1, 32'hFFFF_FFFF);
        random_phase(45);
        set_loop(32'd40, 32'd3145728000);
        random_phase(70);
        set_loop(32'd131072, 32'd3145728000);
        random_phase(90);
        set_loop(32'd65536, 32'd65536);
        random_phase(45);
        set_loop(32'd0, 32'd65536);
        random_phase(20);
        set_loop(32'd262144, 32'd0);
        random_phase(20);
        set_loop($urandom, $urandom);
        random_phase(60);
        set_loop(32'd524288, $urandom_range(32'h0100_0000, 32'h0001_0000));
        random_phase(60);

        drain();
        if (fail_count == 0)
            $display("** midi_loop_note_recorder: PASSED **");
        else
            $display("** midi_loop_note_recorder: FAILED **");
        $finish;
    end

    // overall time limit
    initial
    begin
        #100ms;
        $display("** midi_loop_note_recorder: FAILED **");
        $finish;
    end

endmodule

// File: files.f
design/mlnr_pkg.sv
design/mlnr_divider.sv
design/midi_loop_note_recorder.sv
tb/sv/midi_loop_note_recorder_checker.sv
tb/sv/midi_loop_note_recorder_tb.sv
